[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/isfd_pkg.sv]
// ----------------------------------------------------------------------------
// isfd_pkg
// Types, codes and constants of the serial IMU frame decoder.
// ----------------------------------------------------------------------------
package isfd_pkg;

  // Frame framing
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [3:0] FRAME_LAST  = 4'd10;   // count at which the last byte lands
  localparam int         NUM_CELLS   = 9;       // type byte plus eight data bytes

  // Type bytes on the wire
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Result kinds
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // Signed Q12.16 axis scale = 2 * full scale (raw * fs / 32768 * 65536)
  localparam logic [11:0] SCALE_ACCEL = 12'd32;
  localparam logic [11:0] SCALE_RATE  = 12'd4000;
  localparam logic [11:0] SCALE_ANGLE = 12'd360;

  // Temperature: floor((raw*32768 + 85) / 170), biased by 170*2^23 to stay positive.
  // Halving first leaves a division by 85, done by reciprocal multiply.
  localparam logic [31:0] TEMP_BIAS  = 32'd85 + (32'd170 << 23);
  localparam logic [31:0] TEMP_RECIP = 32'(((64'd1 << 38) + 64'd84) / 64'd85);
  localparam int          RECIP_SHR  = 38;
  // 36.25 in Q16.16 less the 2^23 bias, as 25-bit two's complement
  localparam logic [24:0] TEMP_OFS   = 25'(32'sd2375680 - 32'sd8388608);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] z_raw;
    logic [30:0]        temp_num;   // biased numerator, already halved
  } frame_t;

  function automatic logic [11:0] kind_scale(input logic [1:0] kind);
    logic [11:0] s;
    case (kind)
      KIND_ACCEL: s = SCALE_ACCEL;
      KIND_RATE:  s = SCALE_RATE;
      KIND_ANGLE: s = SCALE_ANGLE;
      default:    s = 12'd0;
    endcase
    return s;
  endfunction

endpackage

[hdl/isfd_byte_cell.sv]
// ----------------------------------------------------------------------------
// isfd_byte_cell
// One byte stage of the frame shift line; takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
module isfd_byte_cell import isfd_pkg::*; (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d_in,
  output logic [7:0] q
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign q = byte_r;

endmodule

[hdl/isfd_conv.sv]
// ----------------------------------------------------------------------------
// isfd_conv
// Scaling pipeline: axis multiply and temperature reciprocal, then output reg.
// ----------------------------------------------------------------------------
module isfd_conv import isfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          frm_valid,
  input  frame_t        frm,
  output logic          frm_ready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,
  output logic [1:0]    out_tuser
);

  logic               s2_v_r;
  logic [1:0]         s2_kind_r;
  logic [27:0]        s2_x_r, s2_y_r, s2_z_r;
  logic [24:0]        s2_q_r;

  logic               out_v_r;
  logic [1:0]         out_kind_r;
  logic [27:0]        out_x_r, out_y_r, out_z_r;
  logic [24:0]        out_temp_r;

  logic               out_en, s2_en;
  logic [12:0]        scale;
  logic signed [28:0] px, py, pz;
  logic [62:0]        pt;

  assign out_en    = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || out_en;
  assign frm_ready = s2_en;

  always_comb begin
    scale = {1'b0, kind_scale(frm.kind)};
    px    = frm.x_raw * $signed(scale);
    py    = frm.y_raw * $signed(scale);
    pz    = frm.z_raw * $signed(scale);
    pt    = 63'(frm.temp_num) * 63'(TEMP_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_v_r <= frm_valid;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && frm_valid) begin
      s2_kind_r <= frm.kind;
      s2_x_r    <= px[27:0];
      s2_y_r    <= py[27:0];
      s2_z_r    <= pz[27:0];
      s2_q_r    <= pt[RECIP_SHR +: 25];
    end
    if (out_en && s2_v_r) begin
      out_kind_r <= s2_kind_r;
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
      out_z_r    <= s2_z_r;
      out_temp_r <= s2_q_r + TEMP_OFS;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_temp_r, out_z_r, out_y_r, out_x_r};

endmodule

[hdl/imu_serial_frame_decoder.sv]
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Eleven-byte IMU frame decoder: header hunt, byte shift line, scaling pipe.
// ----------------------------------------------------------------------------
//  Channel | Ports                                 | Carries
//  --------+---------------------------------------+-------------------------
//  in      | in_tvalid in_tready in_tdata[7:0]     | rx_byte
//  out     | out_tvalid out_tready out_tuser[1:0]  | packet_kind
//          | out_tdata[111:0]                      | x, y, z, temperature
//
//  One byte transaction per cycle sustained while in_tready is high; the
//  shift line and counter take a byte every clock unless stalled. A
//  completed frame passes three registers (capture, multiply, output) in
//  that order before out_tvalid rises.
//  Synchronous active-low reset clears the frame counter and pipe valids;
//  the byte cells hold no reset. in_tready drops only when capture, multiply
//  and output stages are all full and out_tready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_serial_frame_decoder import isfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,     // [7:0] rx_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,    // [27:0] x_value, [55:28] y_value,
                                      // [83:56] z_value, [108:84] temperature,
                                      // [111:109] zero
  output logic [1:0]    out_tuser     // [1:0] packet_kind
);

  logic [3:0]  byte_count_r, byte_count_nxt;
  logic        in_accept;
  logic        collect, frame_done, type_ok;
  logic [1:0]  kind;
  logic [7:0]  cell_q [NUM_CELLS];

  logic        s1_v_r, s1_v_nxt;
  frame_t      s1_r, s1_nxt;
  logic        s1_ready;
  logic [31:0] temp_full;

  assign in_tready = !s1_v_r || s1_ready;
  assign in_accept = in_tvalid && in_tready;

  // Frame counter: 0 means hunting for the header; 1..10 bytes seen.
  always_comb begin
    byte_count_nxt = byte_count_r;
    collect        = 1'b0;
    frame_done     = 1'b0;
    if (in_accept) begin
      if (byte_count_r == 4'd0 || byte_count_r > FRAME_LAST) begin
        byte_count_nxt = (in_tdata == HEADER_BYTE) ? 4'd1 : 4'd0;
      end else begin
        collect = 1'b1;
        if (byte_count_r == FRAME_LAST) begin
          byte_count_nxt = 4'd0;
          frame_done     = 1'b1;      // this byte is the checksum, dropped
        end else begin
          byte_count_nxt = byte_count_r + 4'd1;
        end
      end
    end
  end

  // Shift line: cell 0 takes the new byte, each cell passes its byte on.
  // At frame close cell 8 holds the type, cells 7..0 the little-endian data.
  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        isfd_byte_cell u_cell (
          .clk      (clk),
          .shift_en (collect),
          .d_in     (in_tdata),
          .q        (cell_q[gi])
        );
      end else begin : g_body
        isfd_byte_cell u_cell (
          .clk      (clk),
          .shift_en (collect),
          .d_in     (cell_q[gi-1]),
          .q        (cell_q[gi])
        );
      end
    end
  endgenerate

  // Type decode
  always_comb begin
    kind    = KIND_ACCEL;
    type_ok = 1'b1;
    case (cell_q[8])
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    type_ok = 1'b0;
    endcase
  end

  // Capture stage
  always_comb begin
    temp_full       = {{1{cell_q[0][7]}}, cell_q[0], cell_q[1], 15'd0} + TEMP_BIAS;
    s1_nxt.kind     = kind;
    s1_nxt.x_raw    = $signed({cell_q[6], cell_q[7]});
    s1_nxt.y_raw    = $signed({cell_q[4], cell_q[5]});
    s1_nxt.z_raw    = $signed({cell_q[2], cell_q[3]});
    s1_nxt.temp_num = temp_full[31:1];
    s1_v_nxt        = frame_done && type_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 4'd0;
      s1_v_r       <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      if (in_tready) begin
        s1_v_r <= s1_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && s1_v_nxt) begin
      s1_r <= s1_nxt;
    end
  end

  isfd_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_valid  (s1_v_r),
    .frm        (s1_r),
    .frm_ready  (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Checks
  `ASSERT_ALWAYS(a_count_range, byte_count_r <= FRAME_LAST, "frame counter out of range")
  `ASSERT_IMPLIES(a_capture_src, $rose(s1_v_r), $past(in_accept && byte_count_r == FRAME_LAST), "capture without a closing byte")
  `ASSERT_IMPLIES(a_stall_cause, !in_tready, out_tvalid && !out_tready, "input stalled without output backpressure")
  `ASSERT_IMPLIES(a_kind_legal, out_tvalid, out_tuser != 2'd3, "undefined packet kind on output")

endmodule
